>>> hw/rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a property holds on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/mrte_pkg.sv
package mrte_pkg;

   // Operation numbers
   localparam logic [4:0] OP_AND = 5'd0;
   localparam logic [4:0] OP_NOR = 5'd1;
   localparam logic [4:0] OP_OR = 5'd2;
   localparam logic [4:0] OP_XOR = 5'd3;
   localparam logic [4:0] OP_SLLV = 5'd4;
   localparam logic [4:0] OP_SLL = 5'd5;
   localparam logic [4:0] OP_SRAV = 5'd6;
   localparam logic [4:0] OP_SRA = 5'd7;
   localparam logic [4:0] OP_SRLV = 5'd8;
   localparam logic [4:0] OP_SRL = 5'd9;
   localparam logic [4:0] OP_MFHI = 5'd10;
   localparam logic [4:0] OP_MFLO = 5'd11;
   localparam logic [4:0] OP_MTHI = 5'd12;
   localparam logic [4:0] OP_MTLO = 5'd13;
   localparam logic [4:0] OP_ADD = 5'd14;
   localparam logic [4:0] OP_ADDU = 5'd15;
   localparam logic [4:0] OP_SUB = 5'd16;
   localparam logic [4:0] OP_SUBU = 5'd17;
   localparam logic [4:0] OP_SLT = 5'd18;
   localparam logic [4:0] OP_SLTU = 5'd19;
   localparam logic [4:0] OP_DIV = 5'd20;
   localparam logic [4:0] OP_DIVU = 5'd21;
   localparam logic [4:0] OP_MULT = 5'd22;
   localparam logic [4:0] OP_MULTU = 5'd23;
   localparam logic [4:0] OP_JR = 5'd24;
   localparam logic [4:0] OP_JALR = 5'd25;
   localparam logic [4:0] OP_COP0 = 5'd26;
   localparam logic [4:0] OP_BREAK = 5'd27;
   localparam logic [4:0] OP_SYSCALL = 5'd28;

   // Exception report codes
   localparam logic [1:0] EXC_NONE = 2'd0;
   localparam logic [1:0] EXC_OVF = 2'd1;
   localparam logic [1:0] EXC_BP = 2'd2;
   localparam logic [1:0] EXC_SYS = 2'd3;

   // Cause.ExcCode values
   localparam logic [4:0] CODE_OVF = 5'h0c;
   localparam logic [4:0] CODE_BP = 5'h09;
   localparam logic [4:0] CODE_SYS = 5'h08;

   // Coprocessor 0 register numbers
   localparam logic [4:0] CP0_STATUS = 5'd12;
   localparam logic [4:0] CP0_CAUSE = 5'd13;
   localparam logic [4:0] CP0_EPC = 5'd14;

   localparam logic [31:0] TRAP_VECTOR = 32'hbfc00380;
   localparam logic [4:0] RS_ERET = 5'h10;
   localparam logic [5:0] FUNCT_ERET = 6'h18;
   localparam logic [4:0] RS_MFC0 = 5'h00;
   localparam logic [4:0] RS_MTC0 = 5'h04;

   // Request from the sequencer to the multiply and divide unit
   typedef struct packed {
      logic start;
      logic is_div;
      logic is_signed;
   } md_ctrl_type;

   // Status back from the multiply and divide unit
   typedef struct packed {
      logic done;
      logic [31:0] hi;
      logic [31:0] lo;
   } md_stat_type;

endpackage

>>> hw/rtl/mips_r_type_execute_core.sv
// Most operations go through register read, cp0 read and execute before the result
// is offered; traps also write Cause before the result is offered.
// Multiply and divide also pass through the one-bit-per-cycle
// multiply/divide unit; divide by zero skips it.
// Throughput: one item at a time; the next request is taken the cycle after the
// result transfer. Synchronous active-high reset runs a zeroing sweep over all 32 register file entries.
module mips_r_type_execute_core (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   // [4:0] opcode, [36:5] instruction, [68:37] pc, [69] in_delay_slot
   input logic [71:0] req_tdata,
   output logic rsp_tvalid,
   input logic rsp_tready,
   // [0] reg_write, [5:1] dest_index, [37:6] dest_value, [38] redirect,
   // [70:39] target_address, [71] starts_delay_slot, [73:72] exception,
   // [74] halt
   output logic [79:0] rsp_tdata
);

`include "assert_macros.svh"

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_RD = 3'd2;
   localparam logic [2:0] ST_CP0 = 3'd3;
   localparam logic [2:0] ST_EXE = 3'd4;
   localparam logic [2:0] ST_MD = 3'd5;
   localparam logic [2:0] ST_OUT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [4:0] clr_ff, clr_in;

   // Register files in synchronous memories
   logic [31:0] gpr_a_mem [32];
   logic [31:0] gpr_b_mem [32];
   logic [31:0] cp0_mem [32];
   logic [31:0] rd_a_ff, rd_b_ff, rd_c_ff;
   logic gpr_we;
   logic [4:0] gpr_wa;
   logic [31:0] gpr_wd;
   logic cp0_we;
   logic [4:0] cp0_wa;
   logic [31:0] cp0_wd;
   logic [4:0] gra_a, gra_b, cra;

   logic [4:0] op_ff;
   logic [31:0] ins_ff, pc_ff;
   logic slot_ff;
   logic [31:0] a_ff, b_ff;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [79:0] out_ff, out_in;
   logic [31:0] status_ff, status_in, cause_ff, cause_in;
   logic [1:0] trap_step_ff, trap_step_in;
   logic [31:0] epc_sv_ff, epc_sv_in;

   logic [4:0] rs, rt, rd, sa;
   logic [5:0] funct;
   logic [31:0] a, b, alu_res;
   logic ovf;
   mrte_pkg::md_ctrl_type md_ctrl;
   mrte_pkg::md_stat_type md_stat;

   logic wr;
   logic [4:0] widx;
   logic [31:0] wval, tgt;
   logic redir, ds, halt, trap;
   logic [1:0] exc;
   logic [4:0] code;

   assign rs = ins_ff[25:21];
   assign rt = ins_ff[20:16];
   assign rd = ins_ff[15:11];
   assign sa = ins_ff[10:6];
   assign funct = ins_ff[5:0];
   assign a = (rs == 5'd0) ? 32'd0 : rd_a_ff;
   assign b = (rt == 5'd0) ? 32'd0 : rd_b_ff;

   mrte_alu u_alu (
      .op(op_ff), .a(a_ff), .b(b_ff), .sa(sa), .result(alu_res), .ovf(ovf)
   );

   mrte_muldiv u_md (
      .clock(clock), .reset(reset), .ctrl(md_ctrl), .op_a(a_ff), .op_b(b_ff),
      .stat(md_stat)
   );

   // Memory read addresses
   assign gra_a = (state_ff == ST_IDLE) ? req_tdata[30:26] : rs;
   assign gra_b = (state_ff == ST_IDLE) ? req_tdata[25:21] : rt;
   assign cra = rd;

   always_ff @(posedge clock) begin
      if (gpr_we) begin
         gpr_a_mem[gpr_wa] <= gpr_wd;
         gpr_b_mem[gpr_wa] <= gpr_wd;
      end
      rd_a_ff <= gpr_a_mem[gra_a];
      rd_b_ff <= gpr_b_mem[gra_b];
   end

   always_ff @(posedge clock) begin
      if (cp0_we) cp0_mem[cp0_wa] <= cp0_wd;
      rd_c_ff <= cp0_mem[cra];
   end

   // Decode and execute one item
   always_comb begin
      wr = 1'b0; widx = 5'd0; wval = 32'd0; redir = 1'b0; tgt = 32'd0;
      ds = 1'b0; halt = 1'b0; exc = mrte_pkg::EXC_NONE; trap = 1'b0;
      code = mrte_pkg::CODE_OVF;
      unique case (op_ff)
         mrte_pkg::OP_MFHI: begin wr = 1'b1; widx = rd; wval = hi_ff; end
         mrte_pkg::OP_MFLO: begin wr = 1'b1; widx = rd; wval = lo_ff; end
         mrte_pkg::OP_MTHI, mrte_pkg::OP_MTLO, mrte_pkg::OP_DIV, mrte_pkg::OP_DIVU,
         mrte_pkg::OP_MULT, mrte_pkg::OP_MULTU: ;
         mrte_pkg::OP_ADD, mrte_pkg::OP_SUB: begin
            if (ovf) begin
               trap = 1'b1; exc = mrte_pkg::EXC_OVF; redir = 1'b1;
               tgt = mrte_pkg::TRAP_VECTOR;
            end else begin
               wr = 1'b1; widx = rd; wval = alu_res;
            end
         end
         mrte_pkg::OP_JR: begin redir = 1'b1; tgt = a_ff; ds = 1'b1; end
         mrte_pkg::OP_JALR: begin
            wr = 1'b1; widx = rd; wval = pc_ff + 32'd8;
            redir = 1'b1; tgt = a_ff; ds = 1'b1;
         end
         mrte_pkg::OP_COP0: begin
            if (rs == mrte_pkg::RS_ERET && funct == mrte_pkg::FUNCT_ERET) begin
               redir = 1'b1; tgt = epc_sv_ff;
            end else if (rs == mrte_pkg::RS_MFC0) begin
               wr = 1'b1; widx = rt; wval = rd_c_ff;
            end
         end
         mrte_pkg::OP_BREAK: begin
            trap = 1'b1; exc = mrte_pkg::EXC_BP; redir = 1'b1;
            tgt = mrte_pkg::TRAP_VECTOR; halt = 1'b1; code = mrte_pkg::CODE_BP;
         end
         mrte_pkg::OP_SYSCALL: begin
            trap = 1'b1; exc = mrte_pkg::EXC_SYS; redir = 1'b1;
            tgt = mrte_pkg::TRAP_VECTOR; code = mrte_pkg::CODE_SYS;
         end
         mrte_pkg::OP_AND, mrte_pkg::OP_NOR, mrte_pkg::OP_OR, mrte_pkg::OP_XOR,
         mrte_pkg::OP_SLLV, mrte_pkg::OP_SLL, mrte_pkg::OP_SRAV, mrte_pkg::OP_SRA,
         mrte_pkg::OP_SRLV, mrte_pkg::OP_SRL, mrte_pkg::OP_ADDU, mrte_pkg::OP_SUBU,
         mrte_pkg::OP_SLT, mrte_pkg::OP_SLTU: begin
            wr = 1'b1; widx = rd; wval = alu_res;
         end
         default: ;
      endcase
   end

   // Sequencer; Status, Cause and EPC live in cp0 memory with Status, Cause and
   // EPC mirrored in flops; trap writes go out in turn: Status, then Cause, then EPC
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      out_in = out_ff;
      status_in = status_ff;
      cause_in = cause_ff;
      trap_step_in = 2'd0;
      epc_sv_in = epc_sv_ff;
      gpr_we = 1'b0; gpr_wa = widx; gpr_wd = wval;
      cp0_we = 1'b0; cp0_wa = mrte_pkg::CP0_STATUS; cp0_wd = status_ff;
      md_ctrl = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            gpr_we = 1'b1; gpr_wa = clr_ff; gpr_wd = 32'd0;
            cp0_we = 1'b1; cp0_wa = clr_ff; cp0_wd = 32'd0;
            clr_in = clr_ff + 5'd1;
            if (clr_ff == 5'd31) state_in = ST_IDLE;
         end
         ST_IDLE: if (req_tvalid) state_in = ST_RD;
         ST_RD: state_in = ST_CP0;
         ST_CP0: state_in = ST_EXE;
         ST_EXE: begin
            if (op_ff == mrte_pkg::OP_DIV || op_ff == mrte_pkg::OP_DIVU ||
                op_ff == mrte_pkg::OP_MULT || op_ff == mrte_pkg::OP_MULTU) begin
               if ((op_ff == mrte_pkg::OP_DIV || op_ff == mrte_pkg::OP_DIVU) &&
                   b_ff == 32'd0) begin
                  state_in = ST_OUT;
               end else begin
                  md_ctrl.start = 1'b1;
                  md_ctrl.is_div = (op_ff == mrte_pkg::OP_DIV) ||
                                   (op_ff == mrte_pkg::OP_DIVU);
                  md_ctrl.is_signed = (op_ff == mrte_pkg::OP_DIV) ||
                                      (op_ff == mrte_pkg::OP_MULT);
                  state_in = ST_MD;
               end
            end else begin
               state_in = ST_OUT;
            end
            if (op_ff == mrte_pkg::OP_MTHI) hi_in = a_ff;
            if (op_ff == mrte_pkg::OP_MTLO) lo_in = a_ff;
            gpr_we = wr & (widx != 5'd0);
            if (trap) begin
               cause_in = (cause_ff & 32'hffffff83) | {25'd0, code, 2'd0};
               cause_in[31] = slot_ff;
               status_in = status_ff | 32'd2;
               epc_sv_in = slot_ff ? (pc_ff - 32'd4) : pc_ff;
               trap_step_in = 2'd1;
               cp0_we = 1'b1; cp0_wa = mrte_pkg::CP0_STATUS; cp0_wd = status_in;
            end else if (op_ff == mrte_pkg::OP_COP0) begin
               if (rs == mrte_pkg::RS_ERET && funct == mrte_pkg::FUNCT_ERET) begin
                  status_in = status_ff & 32'hfffffffd;
                  cp0_we = 1'b1; cp0_wa = mrte_pkg::CP0_STATUS; cp0_wd = status_in;
               end else if (rs == mrte_pkg::RS_MTC0) begin
                  cp0_we = 1'b1; cp0_wa = rd; cp0_wd = b_ff;
                  if (rd == mrte_pkg::CP0_STATUS) status_in = b_ff;
                  if (rd == mrte_pkg::CP0_CAUSE) cause_in = b_ff;
                  if (rd == mrte_pkg::CP0_EPC) epc_sv_in = b_ff;
               end
            end
            out_in = {5'd0, halt, exc, ds, tgt, redir, wval, widx, wr};
         end
         ST_MD: begin
            if (md_stat.done) begin
               hi_in = md_stat.hi;
               lo_in = md_stat.lo;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Finish pending trap writes to Cause and EPC
            if (trap_step_ff == 2'd1) begin
               cp0_we = 1'b1; cp0_wa = mrte_pkg::CP0_CAUSE; cp0_wd = cause_ff;
               trap_step_in = 2'd2;
            end else if (trap_step_ff == 2'd2) begin
               cp0_we = 1'b1; cp0_wa = mrte_pkg::CP0_EPC; cp0_wd = epc_sv_ff;
            end
            if (rsp_tready && trap_step_ff != 2'd1) state_in = ST_IDLE;
            else trap_step_in = (trap_step_ff == 2'd1) ? 2'd2 : 2'd0;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= 5'd0;
         hi_ff <= 32'd0;
         lo_ff <= 32'd0;
         status_ff <= 32'd0;
         cause_ff <= 32'd0;
         epc_sv_ff <= 32'd0;
         trap_step_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         status_ff <= status_in;
         cause_ff <= cause_in;
         epc_sv_ff <= epc_sv_in;
         trap_step_ff <= trap_step_in;
      end
      out_ff <= out_in;
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_ff <= req_tdata[4:0];
         ins_ff <= req_tdata[36:5];
         pc_ff <= req_tdata[68:37];
         slot_ff <= req_tdata[69];
      end
      if (state_ff == ST_CP0) begin
         a_ff <= a;
         b_ff <= b;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT) && (trap_step_ff != 2'd1);
   assign rsp_tdata = out_ff;

   `ASSERT_CLK(a_one_side, clock, reset, !(req_tready && rsp_tvalid), "busy overlap")
   `ASSERT_CLK(a_md_done, clock, reset, md_stat.done |-> $past(state_ff) == ST_MD, "stray done")
   `ASSERT_CLK(a_ret_idle, clock, reset, (rsp_tvalid && rsp_tready) |=> req_tready, "no return")

endmodule

>>> hw/rtl/mrte_muldiv.sv
module mrte_muldiv (
   input logic clock,
   input logic reset,
   input mrte_pkg::md_ctrl_type ctrl,
   input logic [31:0] op_a,
   input logic [31:0] op_b,
   output mrte_pkg::md_stat_type stat
);

   logic busy_ff, busy_in;
   logic [5:0] cnt_ff, cnt_in;
   logic is_div_ff, is_div_in;
   logic neg_q_ff, neg_q_in;
   logic neg_r_ff, neg_r_in;
   logic [31:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;
   logic done_ff, done_in;
   logic [31:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in;

   logic na, nb;
   logic [31:0] ua, ub;
   logic [32:0] trial;
   logic [32:0] psum;
   logic [31:0] q_fix, r_fix;
   logic [63:0] p_fix;

   // Take operand magnitudes for signed work
   assign na = ctrl.is_signed & op_a[31];
   assign nb = ctrl.is_signed & op_b[31];
   assign ua = na ? (32'd0 - op_a) : op_a;
   assign ub = nb ? (32'd0 - op_b) : op_b;

   // One restoring divide step or one shift-add multiply step
   assign trial = {acc_ff[63:31]} - {1'b0, b_ff};
   assign psum = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, b_ff} : 33'd0);

   assign q_fix = neg_q_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
   assign r_fix = neg_r_ff ? (32'd0 - acc_ff[63:32]) : acc_ff[63:32];
   assign p_fix = neg_q_ff ? (64'd0 - acc_ff) : acc_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      is_div_in = is_div_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      done_in = 1'b0;
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in = 6'd0;
         is_div_in = ctrl.is_div;
         neg_q_in = na ^ nb;
         neg_r_in = na;
         b_in = ub;
         acc_in = {32'd0, ua};
      end else if (busy_ff) begin
         if (cnt_ff == 6'd32) begin
            // Finish: apply sign and report
            busy_in = 1'b0;
            done_in = 1'b1;
            if (is_div_ff) begin
               hi_in = r_fix;
               lo_in = q_fix;
            end else begin
               hi_in = p_fix[63:32];
               lo_in = p_fix[31:0];
            end
         end else begin
            cnt_in = cnt_ff + 6'd1;
            if (is_div_ff) begin
               if (!trial[32]) acc_in = {trial[31:0], acc_ff[30:0], 1'b1};
               else acc_in = {acc_ff[62:0], 1'b0};
            end else begin
               acc_in = {psum, acc_ff[31:1]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      is_div_ff <= is_div_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign stat.done = done_ff;
   assign stat.hi = hi_ff;
   assign stat.lo = lo_ff;

endmodule

>>> hw/rtl/mrte_alu.sv
module mrte_alu (
   input logic [4:0] op,
   input logic [31:0] a,
   input logic [31:0] b,
   input logic [4:0] sa,
   output logic [31:0] result,
   output logic ovf
);

   logic [4:0] sh;
   logic [31:0] sum, dif;

   assign sh = ((op == mrte_pkg::OP_SLL) || (op == mrte_pkg::OP_SRA) ||
                (op == mrte_pkg::OP_SRL)) ? sa : a[4:0];
   assign sum = a + b;
   assign dif = a - b;

   // Pick the result of one simple operation
   always_comb begin
      result = 32'd0;
      ovf = 1'b0;
      unique case (op)
         mrte_pkg::OP_AND: result = a & b;
         mrte_pkg::OP_NOR: result = ~(a | b);
         mrte_pkg::OP_OR: result = a | b;
         mrte_pkg::OP_XOR: result = a ^ b;
         mrte_pkg::OP_SLLV, mrte_pkg::OP_SLL: result = b << sh;
         mrte_pkg::OP_SRAV, mrte_pkg::OP_SRA: result = 32'($signed(b) >>> sh);
         mrte_pkg::OP_SRLV, mrte_pkg::OP_SRL: result = b >> sh;
         mrte_pkg::OP_ADD: begin
            result = sum;
            ovf = (sum[31] ^ a[31]) & ~(a[31] ^ b[31]);
         end
         mrte_pkg::OP_ADDU: result = sum;
         mrte_pkg::OP_SUB: begin
            result = dif;
            ovf = (dif[31] ^ a[31]) & (a[31] ^ b[31]);
         end
         mrte_pkg::OP_SUBU: result = dif;
         mrte_pkg::OP_SLT: result = {31'd0, $signed(a) < $signed(b)};
         mrte_pkg::OP_SLTU: result = {31'd0, a < b};
         default: result = 32'd0;
      endcase
   end

endmodule
